// ----- hdl/vcsd_pkg.sv -----
// Shared types and constants of the vibration cycle state detector.
// No dependencies; every other file of the block imports this package.
package vcsd_pkg;

  // Machine state codes as they appear in the report.
  localparam logic [1:0] ST_OFF      = 2'd0;
  localparam logic [1:0] ST_WASHING  = 2'd1;
  localparam logic [1:0] ST_SPINNING = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WASH_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] SPIN_THR_RST = 16'd4915;
  localparam logic [15:0] WASH_THR_RST = 16'd819;
  localparam logic [31:0] TIMEOUT_RST  = 32'd180000;

  // Field widths.
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned CNT_W  = 32;

  // The average always fits in MAG_W bits, so the divider only needs
  // one step per quotient bit.
  localparam int unsigned DIV_STEPS = MAG_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming sample
    logic commit;    // apply the evaluated state update
    logic div_start; // load the divider
    logic div_step;  // one restoring division step
    logic out_load;  // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic change;    // evaluated sample changes the machine state
    logic done;      // evaluated sample finishes the cycle
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

// ----- hdl/vcsd_if.sv -----
// Stream interfaces for samples and state-change reports.
// Depends on vcsd_pkg for field widths.
interface vcsd_sample_if
  import vcsd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MAG_W-1:0]  magnitude;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, output magnitude, output time_ms, input ready);
  modport sink   (input valid, input magnitude, input time_ms, output ready);
endinterface

interface vcsd_report_if
  import vcsd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       new_state;
  logic             cycle_done;
  logic [MAG_W-1:0] wash_average;
  logic [MAG_W-1:0] wash_peak;
  logic [MAG_W-1:0] spin_peak;

  modport source (output valid, output new_state, output cycle_done, output wash_average,
                  output wash_peak, output spin_peak, input ready);
  modport sink   (input valid, input new_state, input cycle_done, input wash_average,
                  input wash_peak, input spin_peak, output ready);
endinterface

// ----- hdl/vcsd_ctrl.sv -----
// Controller of the vibration cycle state detector: sequences capture,
// evaluation, division and result hand-off. Depends on vcsd_pkg.
module vcsd_ctrl
  import vcsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PUT  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.commit = 1'b1;
        if (status_i.done) begin
          cmd_o.div_start = 1'b1;
          cnt_d           = '0;
          state_d         = S_DIV;
        end else if (status_i.change) begin
          state_d = S_PUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- hdl/vcsd_dp.sv -----
// Datapath of the vibration cycle state detector: configuration, cycle
// state, wash statistics, the restoring divider and the output register.
// Depends on vcsd_pkg.
module vcsd_dp
  import vcsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TIME_W-1:0]    cfg_data_i,
  input  logic [MAG_W-1:0]     magnitude_i,
  input  logic [TIME_W-1:0]    time_ms_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [1:0]           new_state_o,
  output logic                 cycle_done_o,
  output logic [MAG_W-1:0]     wash_average_o,
  output logic [MAG_W-1:0]     wash_peak_o,
  output logic [MAG_W-1:0]     spin_peak_o
);

  logic [MAG_W-1:0]  spin_thr_q, wash_thr_q;
  logic [TIME_W-1:0] timeout_q;

  logic [MAG_W-1:0]  mag_q;
  logic [TIME_W-1:0] time_q;

  logic [1:0]        mstate_q, mstate_d;
  logic              timer_run_q, timer_run_d;
  logic [TIME_W-1:0] quiet_start_q, quiet_start_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [MAG_W-1:0]  wmax_q, wmax_d;
  logic [MAG_W-1:0]  smax_q, smax_d;
  logic              done_q, done_d;

  logic [CNT_W-1:0]  rem_q;
  logic [MAG_W-1:0]  quo_q;

  logic              out_valid_q;
  logic [1:0]        out_state_q;
  logic              out_done_q;
  logic [MAG_W-1:0]  out_avg_q, out_wpk_q, out_spk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_thr_q <= SPIN_THR_RST;
      wash_thr_q <= WASH_THR_RST;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SPIN_THR: spin_thr_q <= cfg_data_i[MAG_W-1:0];
        CFG_WASH_THR: wash_thr_q <= cfg_data_i[MAG_W-1:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mag_q  <= magnitude_i;
      time_q <= time_ms_i;
    end
  end

  // Classification and state update for the captured sample.
  logic              is_spin, is_wash, idle, new_cycle;
  logic [SUM_W-1:0]  base_sum;
  logic [CNT_W-1:0]  base_cnt;
  logic [MAG_W-1:0]  base_wmax, base_smax;
  logic [TIME_W-1:0] elapsed;

  always_comb begin
    idle      = (mstate_q == ST_OFF) || (mstate_q == ST_FINISHED);
    is_spin   = mag_q > spin_thr_q;
    is_wash   = !is_spin && (mag_q > wash_thr_q);
    new_cycle = idle && (is_spin || is_wash);
    base_sum  = new_cycle ? '0 : sum_q;
    base_cnt  = new_cycle ? '0 : cnt_q;
    base_wmax = new_cycle ? '0 : wmax_q;
    base_smax = new_cycle ? '0 : smax_q;

    mstate_d      = mstate_q;
    timer_run_d   = timer_run_q;
    quiet_start_d = quiet_start_q;
    sum_d         = base_sum;
    cnt_d         = base_cnt;
    wmax_d        = base_wmax;
    smax_d        = base_smax;
    done_d        = 1'b0;
    elapsed       = '0;

    if (is_spin) begin
      mstate_d    = ST_SPINNING;
      timer_run_d = 1'b0;
      if (mag_q > base_smax) begin
        smax_d = mag_q;
      end
    end else if (is_wash) begin
      mstate_d    = ST_WASHING;
      timer_run_d = 1'b0;
      if (base_cnt != '1) begin
        sum_d = base_sum + SUM_W'(mag_q);
        cnt_d = base_cnt + 1'b1;
      end
      if (mag_q > base_wmax) begin
        wmax_d = mag_q;
      end
    end else if (!idle) begin
      if (!timer_run_q) begin
        timer_run_d   = 1'b1;
        quiet_start_d = time_q;
      end
      elapsed = time_q - quiet_start_d;
      if (elapsed > timeout_q) begin
        mstate_d = ST_FINISHED;
        done_d   = 1'b1;
      end
    end
  end

  assign status_o.change   = mstate_d != mstate_q;
  assign status_o.done     = done_d;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstate_q      <= ST_OFF;
      timer_run_q   <= 1'b0;
      quiet_start_q <= '0;
      sum_q         <= '0;
      cnt_q         <= '0;
      wmax_q        <= '0;
      smax_q        <= '0;
      done_q        <= 1'b0;
    end else if (cmd_i.commit) begin
      mstate_q      <= mstate_d;
      timer_run_q   <= timer_run_d;
      quiet_start_q <= quiet_start_d;
      sum_q         <= sum_d;
      cnt_q         <= cnt_d;
      wmax_q        <= wmax_d;
      smax_q        <= smax_d;
      done_q        <= done_d;
    end
  end

  // Restoring divider. The quotient is known to fit in MAG_W bits, so the
  // partial remainder starts from the upper sum bits, which are below the
  // divisor, and the low sum bits are shifted in one per step.
  logic [CNT_W:0] trial;
  logic           fits;

  assign trial = {rem_q, quo_q[MAG_W-1]};
  assign fits  = trial >= {1'b0, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= sum_q[SUM_W-1:MAG_W];
      quo_q <= sum_q[MAG_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? CNT_W'(trial - {1'b0, cnt_q}) : trial[CNT_W-1:0];
      quo_q <= {quo_q[MAG_W-2:0], fits};
    end
  end

  // Output register; statistics are reported only with a finished cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_state_q <= mstate_q;
      out_done_q  <= done_q;
      out_avg_q   <= (done_q && (cnt_q != '0)) ? quo_q : '0;
      out_wpk_q   <= done_q ? wmax_q : '0;
      out_spk_q   <= done_q ? smax_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_state_o    = out_state_q;
  assign cycle_done_o   = out_done_q;
  assign wash_average_o = out_avg_q;
  assign wash_peak_o    = out_wpk_q;
  assign spin_peak_o    = out_spk_q;

endmodule

// ----- hdl/vibration_cycle_state_detector_core.sv -----
// Top level of the vibration cycle state detector.
// Depends on vcsd_pkg, vcsd_if, vcsd_ctrl and vcsd_dp.
//
//   Channel   Direction  Handshake      Payload
//   sample    in         valid/ready    magnitude (Q4.12), time_ms
//   report    out        valid/ready    new_state, cycle_done, wash_average,
//                                       wash_peak, spin_peak
//   cfg       in         cfg_we_i only  cfg_index_i, cfg_data_i
//
// A sample that does not change the state is transferred and then evaluated.
// A plain state change is evaluated and its report is then loaded into the
// output register once that is free. A finishing sample also passes the
// 16-step restoring divider that forms the wash average before the load.
// Reset is asynchronous and active low; it restores the default thresholds
// and timeout and puts the machine in the off state with cleared statistics.
// A stalled report holds in the output register while the next sample is
// taken; the controller only waits when a second report is ready as well.
module vibration_cycle_state_detector_core
  import vcsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TIME_W-1:0]    cfg_data_i,
  vcsd_sample_if.sink          sample,
  vcsd_report_if.source        report
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller owns sequencing: it accepts a sample only when idle and
  // walks it through evaluation, optional division and result hand-off.
  vcsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample.valid),
    .in_ready_o (sample.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds configuration, cycle state, statistics, the divider
  // and the output register that decouples the report channel.
  vcsd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .magnitude_i    (sample.magnitude),
    .time_ms_i      (sample.time_ms),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (report.ready),
    .out_valid_o    (report.valid),
    .new_state_o    (report.new_state),
    .cycle_done_o   (report.cycle_done),
    .wash_average_o (report.wash_average),
    .wash_peak_o    (report.wash_peak),
    .spin_peak_o    (report.spin_peak)
  );

`ifndef SYNTHESIS
  // A finishing report always names the finished state.
  a_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    report.valid && report.cycle_done |-> report.new_state == ST_FINISHED)
    else $error("finishing report without finished state");

  // Reports other than a finishing one carry zero statistics.
  a_zero_stats : assert property (@(posedge clk_i) disable iff (!rst_ni)
    report.valid && !report.cycle_done |->
      report.wash_average == '0 && report.wash_peak == '0 && report.spin_peak == '0)
    else $error("statistics on a non-finishing report");

  // After a sample transfer the block is busy evaluating it.
  a_busy_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample taken while evaluating the previous one");
`endif

endmodule
